// File: hdl/sst_pkg.sv
// Shared types, field widths and codes of the sparse set table.
`default_nettype none

package sst_pkg;

  // Request and result field widths.
  localparam int OPCODE_W = 2;
  localparam int ENTITY_W = 12;
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 11;

  localparam int IN_FIELDS_W = OPCODE_W + ENTITY_W + SLOT_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int RESULT_W    = STATUS_W + SLOT_W + ENTITY_W + TOTAL_W;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RESULT_W;

  // Default table sizes.
  localparam int DEF_MAX_ENTITIES = 4096;
  localparam int DEF_CAPACITY     = 1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_REMOVE,
    OP_READ
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_ALREADY,
    ST_FULL,
    ST_RANGE
  } status_t;

  // Result word, first field in the highest bits.
  typedef struct packed {
    logic [TOTAL_W-1:0]  member_total;
    logic [ENTITY_W-1:0] entity_out;
    logic [SLOT_W-1:0]   slot_out;
    status_t             status;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/sst_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module sst_ram #(
  parameter int DEPTH = 2,
  parameter int DW    = 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/sparse_set_table_core.sv
// Top level of the sparse set table: request decode, sequencing and both memories.
//
// The block keeps a set of entity ids in two synchronous memories. The sparse
// memory holds, for each entity, a present bit and the dense slot it sits in;
// the dense memory holds the member ids packed at slots 0 to count-1. Each
// request (lookup, insert, remove or read-at-slot) gives exactly one result.
// A request is read from both memories in the cycle it is accepted and
// finished in the execute state that follows. Remove then passes through an
// unmark state: it writes the moved member's sparse entry and then clears
// the removed entity's present bit, since the sparse memory has a single
// write port. Requests never overlap, so no entry is read while a write to it
// is pending. After reset the present bits are cleared by a pass over every
// entry of the sparse memory, during which in_tready is low. A finished result
// waits in the output register while the next request is accepted; a request
// only stalls in its execute state if the previous result has still not been
// taken.
`default_nettype none

module sparse_set_table_core import sst_pkg::*; #(
  parameter int MAX_ENTITIES = DEF_MAX_ENTITIES,
  parameter int CAPACITY     = DEF_CAPACITY
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Request channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // opcode[1:0], entity[13:2], slot[23:14]
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // status[2:0], slot_out[12:3],
                                                  // entity_out[24:13], member_total[35:25]
);

  // Index widths: entity index, slot index, member count, sparse word.
  localparam int EW  = $clog2(MAX_ENTITIES);
  localparam int SW  = $clog2(CAPACITY);
  localparam int NW  = $clog2(CAPACITY + 1);
  localparam int SPW = SW + 1;

  localparam logic [EW-1:0] LAST_ENT = EW'(MAX_ENTITIES - 1);
  localparam logic [NW-1:0] CAP_N    = NW'(CAPACITY);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_UNMARK
  } state_t;

  // Registers.
  state_t                state_r, state_nxt;
  logic [EW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [NW-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               res_r, res_nxt;
  op_t                   op_r, op_nxt;
  logic [ENTITY_W-1:0]   ent_r, ent_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;

  // Request fields.
  op_t                   in_op;
  logic [ENTITY_W-1:0]   in_entity;
  logic [SLOT_W-1:0]     in_slot;
  logic [31:0]           in_ent_ext;
  logic [31:0]           in_slot_ext;
  logic                  accept;

  // Memory ports.
  logic                  sp_we, sp_re;
  logic [EW-1:0]         sp_waddr, sp_raddr;
  logic [SPW-1:0]        sp_wdata, sp_rdata;
  logic                  dn_we, dn_re;
  logic [SW-1:0]         dn_waddr, dn_raddr;
  logic [ENTITY_W-1:0]   dn_wdata, dn_rdata;

  // Execute-cycle decode.
  logic [31:0]           ent_ext_r;
  logic [EW-1:0]         ent_idx_r;
  logic [31:0]           moved_ext;
  logic [EW-1:0]         moved_idx;
  logic [NW-1:0]         count_m1;
  logic                  sp_present;
  logic [SW-1:0]         sp_pos;
  logic                  known;
  logic                  present;
  logic                  slot_ok;
  logic                  full;
  logic                  go;
  logic                  ins_ok;
  logic                  rem_ok;
  logic [NW-1:0]         cnt_after;
  result_t               res_c;

  assign in_op      = op_t'(in_tdata[OPCODE_W-1:0]);
  assign in_entity  = in_tdata[OPCODE_W +: ENTITY_W];
  assign in_slot    = in_tdata[OPCODE_W + ENTITY_W +: SLOT_W];
  assign in_ent_ext = 32'(in_entity);
  assign in_slot_ext = 32'(in_slot);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign ent_ext_r  = 32'(ent_r);
  assign ent_idx_r  = ent_ext_r[EW-1:0];
  assign moved_ext  = 32'(dn_rdata);
  assign moved_idx  = moved_ext[EW-1:0];
  assign count_m1   = count_r - NW'(1);
  assign sp_present = sp_rdata[SW];
  assign sp_pos     = sp_rdata[SW-1:0];

  // Ids past the table alias onto real rows when indexed; known masks them out.
  assign known   = ent_ext_r < 32'(MAX_ENTITIES);
  assign present = known && sp_present;
  assign slot_ok = 32'(slot_r) < 32'(count_r);
  assign full    = (count_r == CAP_N);
  assign go      = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Both memories are read when the request is accepted. The dense read is the
  // requested slot for read-at-slot and the last member otherwise.
  assign sp_re    = accept;
  assign sp_raddr = in_ent_ext[EW-1:0];
  assign dn_re    = accept;
  assign dn_raddr = (in_op == OP_READ) ? in_slot_ext[SW-1:0] : count_m1[SW-1:0];

  // Decide the result of the request in the execute cycle.
  always_comb begin
    res_c  = '0;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    case (op_r)
      OP_READ: begin
        if (slot_ok) begin
          res_c.status     = ST_OK;
          res_c.slot_out   = slot_r;
          res_c.entity_out = dn_rdata;
        end else begin
          res_c.status = ST_RANGE;
        end
      end
      OP_LOOKUP: begin
        if (present) begin
          res_c.status     = ST_OK;
          res_c.slot_out   = SLOT_W'(sp_pos);
          res_c.entity_out = ent_r;
        end else begin
          res_c.status = ST_NOT_FOUND;
        end
      end
      OP_INSERT: begin
        if (!known) begin
          res_c.status = ST_RANGE;
        end else if (present) begin
          res_c.status   = ST_ALREADY;
          res_c.slot_out = SLOT_W'(sp_pos);
        end else if (full) begin
          res_c.status = ST_FULL;
        end else begin
          ins_ok           = 1'b1;
          res_c.status     = ST_OK;
          res_c.slot_out   = SLOT_W'(count_r);
          res_c.entity_out = ent_r;
        end
      end
      OP_REMOVE: begin
        // When the removed entity is the last member, moved equals it.
        if (present && (count_r != '0)) begin
          rem_ok           = 1'b1;
          res_c.status     = ST_OK;
          res_c.slot_out   = SLOT_W'(sp_pos);
          res_c.entity_out = dn_rdata;
        end else begin
          res_c.status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_c.status = ST_NOT_FOUND;
      end
    endcase

    if (ins_ok) begin
      cnt_after = count_r + NW'(1);
    end else if (rem_ok) begin
      cnt_after = count_m1;
    end else begin
      cnt_after = count_r;
    end
    res_c.member_total = TOTAL_W'(cnt_after);
  end

  // Memory write ports. Remove first points the moved member at the freed slot,
  // then clears the removed entity's present bit; if the two are the same
  // entity the second write wins and it ends up absent.
  always_comb begin
    sp_we    = 1'b0;
    sp_waddr = ent_idx_r;
    sp_wdata = '0;
    dn_we    = 1'b0;
    dn_waddr = count_r[SW-1:0];
    dn_wdata = ent_r;
    case (state_r)
      S_CLEAR: begin
        sp_we    = 1'b1;
        sp_waddr = clr_addr_r;
      end
      S_EXEC: begin
        if (go && ins_ok) begin
          sp_we    = 1'b1;
          sp_wdata = {1'b1, count_r[SW-1:0]};
          dn_we    = 1'b1;
        end else if (go && rem_ok) begin
          sp_we    = 1'b1;
          sp_waddr = moved_idx;
          sp_wdata = {1'b1, sp_pos};
          dn_we    = 1'b1;
          dn_waddr = sp_pos;
          dn_wdata = dn_rdata;
        end
      end
      S_UNMARK: begin
        sp_we = 1'b1;
      end
      default: begin
        sp_we = 1'b0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    op_nxt        = op_r;
    ent_nxt       = ent_r;
    slot_nxt      = slot_r;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + EW'(1);
        if (clr_addr_r == LAST_ENT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_op;
          ent_nxt   = in_entity;
          slot_nxt  = in_slot;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          count_nxt     = cnt_after;
          out_valid_nxt = 1'b1;
          res_nxt       = res_c;
          state_nxt     = rem_ok ? S_UNMARK : S_IDLE;
        end
      end
      S_UNMARK: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r  <= res_nxt;
    op_r   <= op_nxt;
    ent_r  <= ent_nxt;
    slot_r <= slot_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r};

  // Sparse memory: present bit above the dense slot of each entity.
  sst_ram #(
    .DEPTH (MAX_ENTITIES),
    .DW    (SPW)
  ) u_sparse (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  // Dense memory: member ids packed from slot 0.
  sst_ram #(
    .DEPTH (CAPACITY),
    .DW    (ENTITY_W)
  ) u_dense (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dn_wdata),
    .re    (dn_re),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

endmodule

`default_nettype wire

// File: hdl/sst_checker.sv
// Port-level checks of the sparse set table, bound to the top level.
`default_nettype none

module sst_checker import sst_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  result_t res;
  assign res = result_t'(out_tdata[RESULT_W-1:0]);

  // A result that is not taken stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The clearing pass keeps requests out right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken during the clearing pass");

  // A request is worked on alone: no second one in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("back-to-back request accepted");

  // Failed requests carry no slot or entity, except the slot of already_present.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.status == ST_NOT_FOUND || res.status == ST_FULL ||
                   res.status == ST_RANGE)
    |-> res.slot_out == '0 && res.entity_out == '0)
    else $error("failed request reported a slot or entity");

endmodule

bind sparse_set_table_core sst_checker u_sst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: dv/tb_sparse_set_table_core.sv
// Self-checking testbench for the sparse set table core: random and directed requests.
module tb_sparse_set_table_core import sst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTITIES = DEF_MAX_ENTITIES;
  localparam int CAPACITY     = DEF_CAPACITY;

  // A run that hangs is cut off here. The slowest legal run (longest sender gap
  // plus longest receiver stall on every request, the clearing pass after reset
  // and the long hold-off) stays well below a quarter of this.
  localparam int TIMEOUT_NS = 8_000_000;

  // The receiver stops taking results once this many have arrived, for this
  // many cycles, so that the result register stays full and the input stalls.
  localparam int HOLD_AFTER  = 400;
  localparam int HOLD_CYCLES = 300;

  // Bit positions of the request fields inside in_tdata.
  localparam int ENTITY_LSB = OPCODE_W;
  localparam int SLOT_LSB   = OPCODE_W + ENTITY_W;

  typedef struct {
    op_t                 op;
    logic [ENTITY_W-1:0] entity;
    logic [SLOT_W-1:0]   slot;
  } set_request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  sparse_set_table_core #(
    .MAX_ENTITIES(MAX_ENTITIES),
    .CAPACITY    (CAPACITY)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Requests waiting to be offered, and the results they are predicted to give,
  // oldest first.
  set_request_t request_backlog[$];
  result_t      expected_results[$];

  int unsigned n_planned  = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results  = 0;
  int unsigned n_errors   = 0;

  // ---------------------------------------------------------------------------
  // Predicted contents of the table. The sparse side maps an entity to its
  // slot and marks it present; the dense side holds the members packed from
  // slot zero. Only entries that were written are ever read.
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0]   slot_of_member[MAX_ENTITIES];
  bit                  is_member[MAX_ENTITIES];
  logic [ENTITY_W-1:0] member_at_slot[CAPACITY];
  int unsigned         members = 0;

  // Applies one request to the predicted table and returns its result.
  function automatic result_t predict_set_result(op_t op, logic [ENTITY_W-1:0] ent,
                                                 logic [SLOT_W-1:0] sl);
    result_t             res;
    logic [SLOT_W-1:0]   hole;
    logic [ENTITY_W-1:0] tail;
    res = '0;
    case (op)
      OP_LOOKUP: begin
        if (is_member[ent]) begin
          res.status     = ST_OK;
          res.slot_out   = slot_of_member[ent];
          res.entity_out = ent;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_INSERT: begin
        if (is_member[ent]) begin
          // A member is never duplicated; its current slot is reported.
          res.status   = ST_ALREADY;
          res.slot_out = slot_of_member[ent];
        end else if (members >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot_of_member[ent]     = SLOT_W'(members);
          is_member[ent]          = 1'b1;
          member_at_slot[members] = ent;
          res.status              = ST_OK;
          res.slot_out            = SLOT_W'(members);
          res.entity_out          = ent;
          members++;
        end
      end
      OP_REMOVE: begin
        if (!is_member[ent] || members == 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // The last member fills the hole. When the removed entity is itself
          // the last member it moves onto its own slot and then drops out.
          hole                 = slot_of_member[ent];
          tail                 = member_at_slot[members - 1];
          slot_of_member[tail] = hole;
          member_at_slot[hole] = tail;
          is_member[ent]       = 1'b0;
          members--;
          res.status     = ST_OK;
          res.slot_out   = hole;
          res.entity_out = tail;
        end
      end
      default: begin
        if (sl >= members) begin
          res.status = ST_RANGE;
        end else begin
          res.status     = ST_OK;
          res.slot_out   = sl;
          res.entity_out = member_at_slot[sl];
        end
      end
    endcase
    res.member_total = TOTAL_W'(members);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning. The planner keeps its own record of which entities will
  // be members when each request reaches the block, so that random requests
  // can aim at members and the table can be driven all the way to full.
  // ---------------------------------------------------------------------------
  bit                  planned_member[MAX_ENTITIES];
  int unsigned         planned_pos[MAX_ENTITIES];
  logic [ENTITY_W-1:0] planned_list[$];

  function automatic void plan_request(op_t op, logic [ENTITY_W-1:0] ent,
                                       logic [SLOT_W-1:0] sl);
    set_request_t        req;
    int unsigned         idx;
    logic [ENTITY_W-1:0] tail;
    req.op     = op;
    req.entity = ent;
    req.slot   = sl;
    request_backlog.push_back(req);
    if (op == OP_INSERT && !planned_member[ent] && planned_list.size() < CAPACITY) begin
      planned_member[ent] = 1'b1;
      planned_pos[ent]    = planned_list.size();
      planned_list.push_back(ent);
    end else if (op == OP_REMOVE && planned_member[ent]) begin
      idx               = planned_pos[ent];
      tail              = planned_list[planned_list.size() - 1];
      planned_list[idx] = tail;
      planned_pos[tail] = idx;
      void'(planned_list.pop_back());
      planned_member[ent] = 1'b0;
    end
  endfunction

  // One random request. The weights are percentages for lookup, insert and
  // remove; read-at-slot takes the rest. hit_pct steers lookups, removes and
  // reads toward current members and valid slots; inserts aim at members less
  // often, which gives the occasional already-present answer.
  function automatic void plan_random(int unsigned w_look, int unsigned w_ins,
                                      int unsigned w_rem, int unsigned hit_pct);
    int unsigned         roll;
    int unsigned         aim;
    op_t                 op;
    logic [ENTITY_W-1:0] ent;
    logic [SLOT_W-1:0]   sl;
    roll = $urandom_range(0, 99);
    if (roll < w_look) begin
      op = OP_LOOKUP;
    end else if (roll < w_look + w_ins) begin
      op = OP_INSERT;
    end else if (roll < w_look + w_ins + w_rem) begin
      op = OP_REMOVE;
    end else begin
      op = OP_READ;
    end
    aim = (op == OP_INSERT) ? hit_pct / 4 : hit_pct;
    ent = ENTITY_W'($urandom_range(0, MAX_ENTITIES - 1));
    if (planned_list.size() != 0 && $urandom_range(0, 99) < aim) begin
      ent = planned_list[$urandom_range(0, planned_list.size() - 1)];
    end
    sl = SLOT_W'($urandom_range(0, CAPACITY - 1));
    if (op == OP_READ && planned_list.size() != 0 && $urandom_range(0, 99) < hit_pct) begin
      sl = SLOT_W'($urandom_range(0, planned_list.size() - 1));
    end
    plan_request(op, ent, sl);
  endfunction

  // Idle length in cycles: mostly none, sometimes a few, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic log_failure(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    n_errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. A request stays on the bus until it is taken; the next one
  // follows after a random gap. Every fourth stretch of 150 requests is sent
  // back to back. Each accepted request is predicted at the edge that takes it.
  // ---------------------------------------------------------------------------
  int unsigned  tx_gap = 0;
  set_request_t tx_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(predict_set_result(op_t'(in_tdata[OPCODE_W-1:0]),
                                                      in_tdata[ENTITY_LSB +: ENTITY_W],
                                                      in_tdata[SLOT_LSB +: SLOT_W]));
        n_accepted <= n_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          in_tvalid <= 1'b0;
          tx_gap    <= tx_gap - 1;
        end else if (request_backlog.size() != 0) begin
          tx_next   = request_backlog.pop_front();
          in_tdata  <= {tx_next.slot, tx_next.entity, tx_next.op};
          in_tvalid <= 1'b1;
          tx_gap    <= ((n_accepted / 150) % 4 == 2) ? 0 : pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor. Each result taken is checked field by field against the
  // oldest prediction. The ready line drops at random, stays high through one
  // stretch in four, and is held low once for a long spell while the sender
  // keeps offering.
  // ---------------------------------------------------------------------------
  int unsigned rx_stall = 0;
  int unsigned rx_pause;
  bit          rx_held = 1'b0;
  result_t     rx_seen;
  result_t     rx_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_seen = result_t'(out_tdata[RESULT_W-1:0]);
        if (expected_results.size() == 0) begin
          log_failure($sformatf("result %0d arrived with no request outstanding", n_results));
        end else begin
          rx_want = expected_results.pop_front();
          if (rx_seen.status !== rx_want.status)
            log_failure($sformatf("result %0d: status %0d, expected %0d",
                                  n_results, rx_seen.status, rx_want.status));
          if (rx_seen.slot_out !== rx_want.slot_out)
            log_failure($sformatf("result %0d: slot_out %0d, expected %0d",
                                  n_results, rx_seen.slot_out, rx_want.slot_out));
          if (rx_seen.entity_out !== rx_want.entity_out)
            log_failure($sformatf("result %0d: entity_out %0d, expected %0d",
                                  n_results, rx_seen.entity_out, rx_want.entity_out));
          if (rx_seen.member_total !== rx_want.member_total)
            log_failure($sformatf("result %0d: member_total %0d, expected %0d",
                                  n_results, rx_seen.member_total, rx_want.member_total));
        end
        n_results <= n_results + 1;
      end

      if (rx_stall != 0) begin
        out_tready <= 1'b0;
        rx_stall   <= rx_stall - 1;
      end else if (!rx_held && n_results >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        rx_stall   <= HOLD_CYCLES - 1;
        rx_held    <= 1'b1;
      end else if ((n_results / 150) % 4 != 1 && $urandom_range(0, 3) == 0) begin
        rx_pause = pick_gap();
        if (rx_pause == 0) begin
          out_tready <= 1'b1;
        end else begin
          out_tready <= 1'b0;
          rx_stall   <= rx_pause - 1;
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run. All requests are planned at time zero, reset is
  // held low at the start, and the block then clears its present bits before
  // it raises in_tready for the first time.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ENTITY_W-1:0] fresh;

    // Directed requests on an empty table first: misses, the extreme ids and
    // slots, a duplicate insert, removal of the first member, of the last member
    // (which must leave it absent) and of an entity when the table is empty.
    plan_request(OP_LOOKUP, 12'd0,    10'd0);
    plan_request(OP_REMOVE, 12'd4095, 10'd1023);
    plan_request(OP_READ,   12'd0,    10'd0);
    plan_request(OP_READ,   12'd4095, 10'd1023);
    plan_request(OP_INSERT, 12'd0,    10'd0);
    plan_request(OP_INSERT, 12'd4095, 10'd1023);
    plan_request(OP_INSERT, 12'd0,    10'd512);
    plan_request(OP_LOOKUP, 12'd4095, 10'd0);
    plan_request(OP_READ,   12'd0,    10'd1);
    plan_request(OP_INSERT, 12'hAAA,  10'h155);
    plan_request(OP_INSERT, 12'h555,  10'h2AA);
    plan_request(OP_READ,   12'h555,  10'h2AA);
    plan_request(OP_READ,   12'hAAA,  10'h155);
    plan_request(OP_REMOVE, 12'd0,    10'd0);
    plan_request(OP_LOOKUP, 12'h555,  10'd0);
    plan_request(OP_REMOVE, 12'hAAA,  10'd0);
    plan_request(OP_LOOKUP, 12'hAAA,  10'd0);
    plan_request(OP_REMOVE, 12'hAAA,  10'd0);
    plan_request(OP_REMOVE, 12'd4095, 10'd0);
    plan_request(OP_REMOVE, 12'h555,  10'd0);
    plan_request(OP_REMOVE, 12'h555,  10'd0);
    plan_request(OP_READ,   12'd0,    10'd0);

    // A balanced mix on a small table.
    repeat (150) plan_random(25, 35, 20, 70);

    // Grow the table to capacity, mostly with fresh inserts.
    while (planned_list.size() < CAPACITY) begin
      if ($urandom_range(0, 99) < 85) begin
        do fresh = ENTITY_W'($urandom_range(0, MAX_ENTITIES - 1));
        while (planned_member[fresh]);
        plan_request(OP_INSERT, fresh, SLOT_W'($urandom_range(0, CAPACITY - 1)));
      end else begin
        plan_random(30, 10, 20, 80);
      end
    end

    // With the table full: inserts that must be refused, lookups, and reads
    // at random slots.
    repeat (30) plan_random(20, 50, 0, 50);

    // Shrink it again, with removes of members the most common request.
    repeat (220) plan_random(20, 15, 45, 85);

    n_planned = request_backlog.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_planned) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // A few more cycles to catch any result the block should not have given.
    repeat (10) @(posedge clk);

    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
